>>> hdl/cbmc_pkg.sv
// ----------------------------------------------------------------------------
// cbmc_pkg
// Types, codes and constants shared by the clock button menu controller.
// ----------------------------------------------------------------------------
package cbmc_pkg;

    localparam int SAMPLE_W = 12;
    localparam int CFG_IDX_W = 3;

    // Configuration register defaults
    localparam logic [SAMPLE_W-1:0] RST_ALARM_KEY_MAX = 12'd500;
    localparam logic [SAMPLE_W-1:0] RST_UP_KEY_LOW    = 12'd1700;
    localparam logic [SAMPLE_W-1:0] RST_UP_KEY_HIGH   = 12'd2200;
    localparam logic [SAMPLE_W-1:0] RST_DOWN_KEY_LOW  = 12'd2300;
    localparam logic [SAMPLE_W-1:0] RST_DOWN_KEY_HIGH = 12'd2600;
    localparam logic [SAMPLE_W-1:0] RST_SET_KEY_HIGH  = 12'd2800;

    // Edit ranges
    localparam logic [6:0] MOD_HOURS   = 7'd24;
    localparam logic [6:0] MOD_MINUTES = 7'd60;
    localparam logic [6:0] MOD_YEAR    = 7'd100;
    localparam logic [4:0] TOP_MONTH   = 5'd12;
    localparam logic [4:0] TOP_DAY     = 5'd31;

    // Seconds at which the idle display rotates to the next view
    localparam logic [5:0] SEC_DATE_FIRST  = 6'd46;
    localparam logic [5:0] SEC_TEMP_FIRST  = 6'd50;
    localparam logic [5:0] SEC_HUMID_FIRST = 6'd54;
    localparam logic [5:0] SEC_HUMID_LAST  = 6'd57;

    localparam logic [1:0] VIEW_TIME  = 2'd0;
    localparam logic [1:0] VIEW_DATE  = 2'd1;
    localparam logic [1:0] VIEW_TEMP  = 2'd2;
    localparam logic [1:0] VIEW_HUMID = 2'd3;

    localparam logic [1:0] FIELD_FIRST  = 2'd0;
    localparam logic [1:0] FIELD_SECOND = 2'd1;
    localparam logic [1:0] FIELD_THIRD  = 2'd2;

    typedef enum logic [0:0] {
        CMD_SCAN = 1'b0,
        CMD_RTC  = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        KEY_NONE  = 3'd0,
        KEY_SET   = 3'd1,
        KEY_DOWN  = 3'd2,
        KEY_UP    = 3'd3,
        KEY_ALARM = 3'd4
    } key_t;

    typedef enum logic [1:0] {
        MODE_TIME = 2'd0,
        MODE_MAIN = 2'd1,
        MODE_SUB  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ENTRY_TIME  = 2'd0,
        ENTRY_DATE  = 2'd1,
        ENTRY_ALARM = 2'd2
    } entry_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALARM_KEY_MAX = 3'd0,
        CFG_UP_KEY_LOW    = 3'd1,
        CFG_UP_KEY_HIGH   = 3'd2,
        CFG_DOWN_KEY_LOW  = 3'd3,
        CFG_DOWN_KEY_HIGH = 3'd4,
        CFG_SET_KEY_HIGH  = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] alarm_key_max;
        logic [SAMPLE_W-1:0] up_key_low;
        logic [SAMPLE_W-1:0] up_key_high;
        logic [SAMPLE_W-1:0] down_key_low;
        logic [SAMPLE_W-1:0] down_key_high;
        logic [SAMPLE_W-1:0] set_key_high;
    } key_cfg_t;

    typedef struct packed {
        logic                cmd;
        logic [SAMPLE_W-1:0] key_sample;
        logic [4:0]          rtc_hours;
        logic [5:0]          rtc_minutes;
        logic [5:0]          rtc_seconds;
        logic [6:0]          rtc_year;
        logic [3:0]          rtc_month;
        logic [4:0]          rtc_day;
    } item_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] menu_item;
        logic [1:0] field_item;
        logic [4:0] hours_now;
        logic [5:0] minutes_now;
        logic [5:0] seconds_now;
        logic [6:0] year_now;
        logic [3:0] month_now;
        logic [4:0] day_now;
        logic       commit_time;
        logic       commit_date;
        logic [1:0] view;
    } result_t;

endpackage

>>> hdl/cbmc_if.sv
// ----------------------------------------------------------------------------
// cbmc_if
// Valid/ready channels of the controller: scan items, results, config writes.
// ----------------------------------------------------------------------------
interface cbmc_item_if;
    logic            valid;
    logic            ready;
    cbmc_pkg::item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cbmc_result_if;
    logic              valid;
    logic              ready;
    cbmc_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cbmc_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [cbmc_pkg::CFG_IDX_W-1:0]      index;
    logic [cbmc_pkg::SAMPLE_W-1:0]       wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

>>> hdl/cbmc_key_dec.sv
// ----------------------------------------------------------------------------
// cbmc_key_dec
// Decodes one ladder sample into a key against the configured windows.
// ----------------------------------------------------------------------------
module cbmc_key_dec
(
    input  logic [cbmc_pkg::SAMPLE_W-1:0] sample,
    input  cbmc_pkg::key_cfg_t            key_cfg,
    output cbmc_pkg::key_t                key
);

    // Windows are tested in fixed order; first match wins
    always_comb
    begin
        priority if (sample <= key_cfg.alarm_key_max)
        begin
            key = cbmc_pkg::KEY_ALARM;
        end
        else if (sample > key_cfg.up_key_low && sample < key_cfg.up_key_high)
        begin
            key = cbmc_pkg::KEY_UP;
        end
        else if (sample > key_cfg.down_key_low && sample < key_cfg.down_key_high)
        begin
            key = cbmc_pkg::KEY_DOWN;
        end
        else if (sample > key_cfg.down_key_high && sample < key_cfg.set_key_high)
        begin
            key = cbmc_pkg::KEY_SET;
        end
        else
        begin
            key = cbmc_pkg::KEY_NONE;
        end
    end

endmodule

>>> hdl/cbmc_menu_core.sv
// ----------------------------------------------------------------------------
// cbmc_menu_core
// Menu state, clock/date registers and edit logic; forms one result per word.
// ----------------------------------------------------------------------------
module cbmc_menu_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  cbmc_pkg::item_t   item,
    input  cbmc_pkg::key_t    key,
    output cbmc_pkg::result_t result
);

    cbmc_pkg::mode_t  mode_reg, mode_next;
    cbmc_pkg::entry_t entry_reg, entry_next;
    cbmc_pkg::key_t   last_key_reg, last_key_next;
    logic [1:0]       field_reg, field_next;
    logic [4:0]       hours_reg, hours_next;
    logic [5:0]       minutes_reg, minutes_next;
    logic [5:0]       seconds_reg, seconds_next;
    logic [6:0]       year_reg, year_next;
    logic [3:0]       month_reg, month_next;
    logic [4:0]       day_reg, day_next;
    logic             commit_time;
    logic             commit_date;
    logic             press;
    logic             step_up;
    logic [6:0]       hours_step;
    logic [6:0]       minutes_step;
    logic [6:0]       year_step;
    logic [4:0]       month_step;
    logic [4:0]       day_step;
    logic [1:0]       view;

    // (v + d + m) mod m; the sum stays below 3*m for any stored value
    function automatic logic [6:0] step_wrap(input logic [6:0] v, input logic up,
                                             input logic [6:0] m);
        logic [7:0] s;
        logic [7:0] m2;
        begin
            m2 = {m, 1'b0};
            s  = {1'b0, v} + {1'b0, m} + (up ? 8'd1 : 8'hFF);
            if (s >= m2)
            begin
                s = s - m2;
            end
            else if (s >= {1'b0, m})
            begin
                s = s - {1'b0, m};
            end
            step_wrap = s[6:0];
        end
    endfunction

    // One-based wrap: above top goes to 1, below 1 goes to top
    function automatic logic [4:0] step_one(input logic [4:0] v, input logic up,
                                            input logic [4:0] top);
        logic [5:0] r;
        begin
            r = up ? ({1'b0, v} + 6'd1) : ({1'b0, v} - 6'd1);
            if (!up && v <= 5'd1)
            begin
                step_one = top;
            end
            else if (r > {1'b0, top})
            begin
                step_one = 5'd1;
            end
            else
            begin
                step_one = r[4:0];
            end
        end
    endfunction

    assign step_up      = (key == cbmc_pkg::KEY_UP);
    assign hours_step   = step_wrap({2'b00, hours_reg}, step_up, cbmc_pkg::MOD_HOURS);
    assign minutes_step = step_wrap({1'b0, minutes_reg}, step_up, cbmc_pkg::MOD_MINUTES);
    assign year_step    = step_wrap(year_reg, step_up, cbmc_pkg::MOD_YEAR);
    assign month_step   = step_one({1'b0, month_reg}, step_up, cbmc_pkg::TOP_MONTH);
    assign day_step     = step_one(day_reg, step_up, cbmc_pkg::TOP_DAY);

    assign press = (item.cmd == cbmc_pkg::CMD_SCAN) && (key != cbmc_pkg::KEY_NONE)
                   && (key != last_key_reg);

    // Next state
    always_comb
    begin
        mode_next     = mode_reg;
        entry_next    = entry_reg;
        field_next    = field_reg;
        last_key_next = last_key_reg;
        hours_next    = hours_reg;
        minutes_next  = minutes_reg;
        seconds_next  = seconds_reg;
        year_next     = year_reg;
        month_next    = month_reg;
        day_next      = day_reg;
        commit_time   = 1'b0;
        commit_date   = 1'b0;

        if (item.cmd == cbmc_pkg::CMD_SCAN)
        begin
            last_key_next = key;
            if (press)
            begin
                unique case (mode_reg)
                    cbmc_pkg::MODE_TIME:
                    begin
                        if (key == cbmc_pkg::KEY_SET)
                        begin
                            mode_next  = cbmc_pkg::MODE_MAIN;
                            entry_next = cbmc_pkg::ENTRY_TIME;
                        end
                    end
                    cbmc_pkg::MODE_MAIN:
                    begin
                        unique case (key)
                            cbmc_pkg::KEY_SET:
                            begin
                                mode_next = cbmc_pkg::MODE_TIME;
                            end
                            cbmc_pkg::KEY_UP:
                            begin
                                if (entry_reg == cbmc_pkg::ENTRY_ALARM
                                    || entry_reg == cbmc_pkg::entry_t'(2'd3))
                                begin
                                    entry_next = cbmc_pkg::ENTRY_TIME;
                                end
                                else
                                begin
                                    entry_next = cbmc_pkg::entry_t'(entry_reg + 2'd1);
                                end
                            end
                            cbmc_pkg::KEY_DOWN:
                            begin
                                if (entry_reg == cbmc_pkg::ENTRY_TIME)
                                begin
                                    entry_next = cbmc_pkg::ENTRY_ALARM;
                                end
                                else
                                begin
                                    entry_next = cbmc_pkg::entry_t'(entry_reg - 2'd1);
                                end
                            end
                            cbmc_pkg::KEY_ALARM:
                            begin
                                mode_next  = cbmc_pkg::MODE_SUB;
                                field_next = cbmc_pkg::FIELD_FIRST;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    cbmc_pkg::MODE_SUB:
                    begin
                        if (key == cbmc_pkg::KEY_ALARM)
                        begin
                            unique case (entry_reg)
                                cbmc_pkg::ENTRY_TIME:
                                begin
                                    if (field_reg == cbmc_pkg::FIELD_FIRST)
                                    begin
                                        field_next = cbmc_pkg::FIELD_SECOND;
                                    end
                                    else
                                    begin
                                        commit_time = 1'b1;
                                        mode_next   = cbmc_pkg::MODE_MAIN;
                                    end
                                end
                                cbmc_pkg::ENTRY_DATE:
                                begin
                                    if (field_reg < cbmc_pkg::FIELD_THIRD)
                                    begin
                                        field_next = field_reg + 2'd1;
                                    end
                                    else
                                    begin
                                        commit_date = 1'b1;
                                        mode_next   = cbmc_pkg::MODE_MAIN;
                                    end
                                end
                                cbmc_pkg::ENTRY_ALARM:
                                begin
                                    if (field_reg < cbmc_pkg::FIELD_THIRD)
                                    begin
                                        field_next = field_reg + 2'd1;
                                    end
                                    else
                                    begin
                                        mode_next = cbmc_pkg::MODE_MAIN;
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        else if (key == cbmc_pkg::KEY_UP || key == cbmc_pkg::KEY_DOWN)
                        begin
                            if (entry_reg == cbmc_pkg::ENTRY_TIME)
                            begin
                                if (field_reg == cbmc_pkg::FIELD_FIRST)
                                begin
                                    hours_next = hours_step[4:0];
                                end
                                if (field_reg == cbmc_pkg::FIELD_SECOND)
                                begin
                                    minutes_next = minutes_step[5:0];
                                end
                            end
                            else if (entry_reg == cbmc_pkg::ENTRY_DATE)
                            begin
                                if (field_reg == cbmc_pkg::FIELD_FIRST)
                                begin
                                    year_next = year_step;
                                end
                                if (field_reg == cbmc_pkg::FIELD_SECOND)
                                begin
                                    month_next = month_step[3:0];
                                end
                                if (field_reg == cbmc_pkg::FIELD_THIRD)
                                begin
                                    day_next = day_step;
                                end
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        else if (mode_reg == cbmc_pkg::MODE_TIME)
        begin
            hours_next   = item.rtc_hours;
            minutes_next = item.rtc_minutes;
            seconds_next = item.rtc_seconds;
            year_next    = item.rtc_year;
            month_next   = item.rtc_month;
            day_next     = item.rtc_day;
        end
    end

    // Outputs: view follows the updated seconds while time is shown
    always_comb
    begin
        view = cbmc_pkg::VIEW_TIME;
        if (mode_next == cbmc_pkg::MODE_TIME)
        begin
            priority if (seconds_next >= cbmc_pkg::SEC_DATE_FIRST
                         && seconds_next < cbmc_pkg::SEC_TEMP_FIRST)
            begin
                view = cbmc_pkg::VIEW_DATE;
            end
            else if (seconds_next >= cbmc_pkg::SEC_TEMP_FIRST
                     && seconds_next < cbmc_pkg::SEC_HUMID_FIRST)
            begin
                view = cbmc_pkg::VIEW_TEMP;
            end
            else if (seconds_next >= cbmc_pkg::SEC_HUMID_FIRST
                     && seconds_next <= cbmc_pkg::SEC_HUMID_LAST)
            begin
                view = cbmc_pkg::VIEW_HUMID;
            end
            else
            begin
                view = cbmc_pkg::VIEW_TIME;
            end
        end

        result.mode        = mode_next;
        result.menu_item   = entry_next;
        result.field_item  = field_next;
        result.hours_now   = hours_next;
        result.minutes_now = minutes_next;
        result.seconds_now = seconds_next;
        result.year_now    = year_next;
        result.month_now   = month_next;
        result.day_now     = day_next;
        result.commit_time = commit_time;
        result.commit_date = commit_date;
        result.view        = view;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= cbmc_pkg::MODE_TIME;
            entry_reg    <= cbmc_pkg::ENTRY_TIME;
            field_reg    <= cbmc_pkg::FIELD_FIRST;
            last_key_reg <= cbmc_pkg::KEY_NONE;
            hours_reg    <= '0;
            minutes_reg  <= '0;
            seconds_reg  <= '0;
            year_reg     <= '0;
            month_reg    <= '0;
            day_reg      <= '0;
        end
        else if (fire)
        begin
            mode_reg     <= mode_next;
            entry_reg    <= entry_next;
            field_reg    <= field_next;
            last_key_reg <= last_key_next;
            hours_reg    <= hours_next;
            minutes_reg  <= minutes_next;
            seconds_reg  <= seconds_next;
            year_reg     <= year_next;
            month_reg    <= month_next;
            day_reg      <= day_next;
        end
    end

endmodule

>>> hdl/clock_button_menu_controller_unit.sv
// ----------------------------------------------------------------------------
// clock_button_menu_controller_unit
// Keypad-driven clock set-up menu with RTC load, two-stage valid/ready pipe.
// ----------------------------------------------------------------------------
//  channel   dir   word                     accepted when
//  scan      in    cbmc_pkg::item_t         scan.valid && scan.ready
//  result    out   cbmc_pkg::result_t       result.valid && result.ready
//  cfg       in    index[2:0], wdata[11:0]  cfg.valid (ready always high)
//
//  One word per cycle sustained while result.ready is high; a scan word is
//  captured in the input register when it is taken and then moves to the
//  result register, whose output carries it as a valid result word.
//  The result register holds while result.ready is low; the input register
//  keeps taking a word as long as the word ahead of it can move.
//  Reset clears menu state, clock/date fields and loads the default windows.
// ----------------------------------------------------------------------------
module clock_button_menu_controller_unit
(
    input  logic         clk,
    input  logic         rst_n,
    cbmc_cfg_if.sink     cfg,
    cbmc_item_if.sink    scan,
    cbmc_result_if.source result
);

    cbmc_pkg::key_cfg_t key_cfg_reg;
    cbmc_pkg::item_t    s1_item_reg;
    logic               s1_valid_reg;
    cbmc_pkg::result_t  res_data_reg;
    logic               res_valid_reg;
    cbmc_pkg::key_t     key;
    cbmc_pkg::result_t  core_result;
    logic               advance;
    logic               fire;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_cfg_reg.alarm_key_max <= cbmc_pkg::RST_ALARM_KEY_MAX;
            key_cfg_reg.up_key_low    <= cbmc_pkg::RST_UP_KEY_LOW;
            key_cfg_reg.up_key_high   <= cbmc_pkg::RST_UP_KEY_HIGH;
            key_cfg_reg.down_key_low  <= cbmc_pkg::RST_DOWN_KEY_LOW;
            key_cfg_reg.down_key_high <= cbmc_pkg::RST_DOWN_KEY_HIGH;
            key_cfg_reg.set_key_high  <= cbmc_pkg::RST_SET_KEY_HIGH;
        end
        else if (cfg.valid)
        begin
            // Drop writes beyond the register list
            unique case (cbmc_pkg::cfg_idx_t'(cfg.index))
                cbmc_pkg::CFG_ALARM_KEY_MAX: key_cfg_reg.alarm_key_max <= cfg.wdata;
                cbmc_pkg::CFG_UP_KEY_LOW:    key_cfg_reg.up_key_low    <= cfg.wdata;
                cbmc_pkg::CFG_UP_KEY_HIGH:   key_cfg_reg.up_key_high   <= cfg.wdata;
                cbmc_pkg::CFG_DOWN_KEY_LOW:  key_cfg_reg.down_key_low  <= cfg.wdata;
                cbmc_pkg::CFG_DOWN_KEY_HIGH: key_cfg_reg.down_key_high <= cfg.wdata;
                cbmc_pkg::CFG_SET_KEY_HIGH:  key_cfg_reg.set_key_high  <= cfg.wdata;
                default:
                begin
                end
            endcase
        end
    end

    assign advance    = !res_valid_reg || result.ready;
    assign fire       = s1_valid_reg && advance;
    assign scan.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (scan.valid && scan.ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan.valid && scan.ready)
        begin
            s1_item_reg <= scan.data;
        end
    end

    cbmc_key_dec u_key_dec
    (
        .sample  (s1_item_reg.key_sample),
        .key_cfg (key_cfg_reg),
        .key     (key)
    );

    cbmc_menu_core u_menu_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (s1_item_reg),
        .key    (key),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_data_reg <= core_result;
        end
    end

    assign result.valid = res_valid_reg;
    assign result.data  = res_data_reg;

    // Both commits come from exclusive sub-menu entries
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !(res_data_reg.commit_time && res_data_reg.commit_date))
        else $error("time and date commit in the same word");

    // A time commit always lands back in the main menu on the time entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_data_reg.commit_time) |->
            (res_data_reg.mode == cbmc_pkg::MODE_MAIN
             && res_data_reg.menu_item == cbmc_pkg::ENTRY_TIME))
        else $error("time commit outside main menu time entry");

    // Rotating views only while time is shown
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_data_reg.view != cbmc_pkg::VIEW_TIME) |->
            res_data_reg.mode == cbmc_pkg::MODE_TIME)
        else $error("view rotates outside time mode");

    // A word in the input stage moves to the result register when it can
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> res_valid_reg)
        else $error("word lost between stages");

endmodule

>>> tb/tb_clock_button_menu_controller_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_clock_button_menu_controller_unit
// Self-checking bench for the clock set-up menu controller. Scan and RTC words
// go in through a valid/ready channel with random gaps. A local model of the
// menu, the key windows and the clock fields predicts each readout word. The
// readout words are then compared field by field in order. Key windows are
// rewritten between phases, only when nothing is in flight.
// ----------------------------------------------------------------------------
module tb_clock_button_menu_controller_unit;
    import cbmc_pkg::*;

    // Indexes past the register list: writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
    localparam int DRAIN_LIMIT = 20000;
    localparam int PIPE_SLACK  = 8;
    localparam int PRINT_CAP   = 40;

    logic clk;
    logic rst_n;

    cbmc_cfg_if    cfg_ch ();
    cbmc_item_if   scan_ch ();
    cbmc_result_if res_ch ();

    clock_button_menu_controller_unit i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .scan   (scan_ch),
        .result (res_ch)
    );

    // Local copy of the windows and the menu/clock state
    key_cfg_t   win;
    mode_t      m_mode;
    entry_t     m_entry;
    logic [1:0] m_field;
    key_t       m_prev_key;
    logic [4:0] m_hours;
    logic [5:0] m_minutes;
    logic [5:0] m_seconds;
    logic [6:0] m_year;
    logic [3:0] m_month;
    logic [4:0] m_day;

    result_t    readout_q [$];
    int         mismatch_cnt;
    bit         src_quiet;
    bit         sink_quiet;
    bit         scan_held;
    bit         cfg_held;

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Model of the block
    // ------------------------------------------------------------------
    function automatic key_t decode_sample(input logic [SAMPLE_W-1:0] s);
        if (s <= win.alarm_key_max) return KEY_ALARM;
        if (s > win.up_key_low && s < win.up_key_high) return KEY_UP;
        if (s > win.down_key_low && s < win.down_key_high) return KEY_DOWN;
        if (s > win.down_key_high && s < win.set_key_high) return KEY_SET;
        return KEY_NONE;
    endfunction

    function automatic int wrap_mod(input int v, input int d, input int m);
        return (v + d + m) % m;
    endfunction

    function automatic int wrap_one(input int v, input int d, input int top);
        int r;
        r = v + d;
        if (r > top)
            r = 1;
        else if (r < 1)
            r = top;
        return r;
    endfunction

    task automatic apply_press(input key_t k, inout bit ct, inout bit cd);
        int d;
        d = (k == KEY_UP) ? 1 : -1;
        case (m_mode)
            MODE_TIME:
            begin
                if (k == KEY_SET)
                begin
                    m_mode  = MODE_MAIN;
                    m_entry = ENTRY_TIME;
                end
            end
            MODE_MAIN:
            begin
                case (k)
                    KEY_SET:   m_mode = MODE_TIME;
                    KEY_UP:
                    begin
                        case (m_entry)
                            ENTRY_TIME: m_entry = ENTRY_DATE;
                            ENTRY_DATE: m_entry = ENTRY_ALARM;
                            default:    m_entry = ENTRY_TIME;
                        endcase
                    end
                    KEY_DOWN:
                    begin
                        case (m_entry)
                            ENTRY_TIME: m_entry = ENTRY_ALARM;
                            ENTRY_DATE: m_entry = ENTRY_TIME;
                            default:    m_entry = ENTRY_DATE;
                        endcase
                    end
                    KEY_ALARM:
                    begin
                        m_mode  = MODE_SUB;
                        m_field = FIELD_FIRST;
                    end
                    default: ;
                endcase
            end
            MODE_SUB:
            begin
                if (k == KEY_ALARM)
                begin
                    // time entry has two fields, date and alarm entries three
                    if (m_entry == ENTRY_TIME && m_field == FIELD_FIRST)
                        m_field = FIELD_SECOND;
                    else if (m_entry != ENTRY_TIME && m_field < FIELD_THIRD)
                        m_field = m_field + 2'd1;
                    else
                    begin
                        ct     = (m_entry == ENTRY_TIME);
                        cd     = (m_entry == ENTRY_DATE);
                        m_mode = MODE_MAIN;
                    end
                end
                else if (k == KEY_UP || k == KEY_DOWN)
                begin
                    if (m_entry == ENTRY_TIME)
                    begin
                        if (m_field == FIELD_FIRST)
                            m_hours = 5'(wrap_mod(m_hours, d, MOD_HOURS));
                        if (m_field == FIELD_SECOND)
                            m_minutes = 6'(wrap_mod(m_minutes, d, MOD_MINUTES));
                    end
                    else if (m_entry == ENTRY_DATE)
                    begin
                        if (m_field == FIELD_FIRST)
                            m_year = 7'(wrap_mod(m_year, d, MOD_YEAR));
                        if (m_field == FIELD_SECOND)
                            m_month = 4'(wrap_one(m_month, d, TOP_MONTH));
                        if (m_field == FIELD_THIRD)
                            m_day = 5'(wrap_one(m_day, d, TOP_DAY));
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic predict_readout(input item_t w, output result_t r);
        key_t k;
        bit   ct;
        bit   cd;
        ct = 1'b0;
        cd = 1'b0;
        if (w.cmd == CMD_SCAN)
        begin
            k = decode_sample(w.key_sample);
            if (k != KEY_NONE && k != m_prev_key)
                apply_press(k, ct, cd);
            m_prev_key = k;
        end
        else if (m_mode == MODE_TIME)
        begin
            m_hours   = w.rtc_hours;
            m_minutes = w.rtc_minutes;
            m_seconds = w.rtc_seconds;
            m_year    = w.rtc_year;
            m_month   = w.rtc_month;
            m_day     = w.rtc_day;
        end
        r.mode        = m_mode;
        r.menu_item   = m_entry;
        r.field_item  = m_field;
        r.hours_now   = m_hours;
        r.minutes_now = m_minutes;
        r.seconds_now = m_seconds;
        r.year_now    = m_year;
        r.month_now   = m_month;
        r.day_now     = m_day;
        r.commit_time = ct;
        r.commit_date = cd;
        r.view        = VIEW_TIME;
        if (m_mode == MODE_TIME)
        begin
            if (m_seconds >= SEC_DATE_FIRST && m_seconds < SEC_TEMP_FIRST)
                r.view = VIEW_DATE;
            else if (m_seconds >= SEC_TEMP_FIRST && m_seconds < SEC_HUMID_FIRST)
                r.view = VIEW_TEMP;
            else if (m_seconds >= SEC_HUMID_FIRST && m_seconds <= SEC_HUMID_LAST)
                r.view = VIEW_HUMID;
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic flag_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= PRINT_CAP)
            $display("%0t ns  mismatch: %s", $time, msg);
    endtask

    task automatic cmp_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task automatic check_readout(input result_t got, input result_t want);
        cmp_field("mode", got.mode, want.mode);
        cmp_field("menu_item", got.menu_item, want.menu_item);
        cmp_field("field_item", got.field_item, want.field_item);
        cmp_field("hours_now", got.hours_now, want.hours_now);
        cmp_field("minutes_now", got.minutes_now, want.minutes_now);
        cmp_field("seconds_now", got.seconds_now, want.seconds_now);
        cmp_field("year_now", got.year_now, want.year_now);
        cmp_field("month_now", got.month_now, want.month_now);
        cmp_field("day_now", got.day_now, want.day_now);
        cmp_field("commit_time", got.commit_time, want.commit_time);
        cmp_field("commit_date", got.commit_date, want.commit_date);
        cmp_field("view", got.view, want.view);
    endtask

    // Predict on every accepted scan word, check every accepted readout word
    always @(posedge clk)
    begin : readout_check
        result_t want;
        if (rst_n)
        begin
            if (scan_ch.valid && scan_ch.ready)
            begin
                predict_readout(scan_ch.data, want);
                readout_q.push_back(want);
            end
            if (res_ch.valid && res_ch.ready)
            begin
                if (readout_q.size() == 0)
                    flag_mismatch($sformatf("unexpected readout word %h", res_ch.data));
                else
                begin
                    want = readout_q.pop_front();
                    check_readout(res_ch.data, want);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Readout stalls
    initial
    begin : readout_sink
        int hold;
        hold = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
                hold--;
            else if (!sink_quiet && $urandom_range(0, 3) == 0)
            begin
                res_ch.ready <= 1'b0;
                hold = pick_gap() - 1;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // Leave valid high when the next word follows at once
    task automatic send_word(input item_t w);
        int gap;
        scan_ch.data <= w;
        if (!scan_held)
            scan_ch.valid <= 1'b1;
        scan_held = 1'b1;
        @(posedge clk);
        while (!scan_ch.ready)
            @(posedge clk);
        gap = 0;
        if (!src_quiet && $urandom_range(0, 2) == 0)
            gap = pick_gap();
        if (gap > 0)
        begin
            scan_ch.valid <= 1'b0;
            scan_held = 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_readouts();
        int waited;
        if (scan_held)
        begin
            scan_ch.valid <= 1'b0;
            scan_held = 1'b0;
        end
        waited = 0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (readout_q.size() != 0 && waited < DRAIN_LIMIT);
        if (readout_q.size() != 0)
        begin
            flag_mismatch($sformatf("%0d readout words never came", readout_q.size()));
            readout_q.delete();
        end
        repeat (PIPE_SLACK) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [SAMPLE_W-1:0] val);
        cfg_ch.index <= idx;
        cfg_ch.wdata <= val;
        if (!cfg_held)
            cfg_ch.valid <= 1'b1;
        cfg_held = 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            CFG_ALARM_KEY_MAX: win.alarm_key_max = val;
            CFG_UP_KEY_LOW:    win.up_key_low    = val;
            CFG_UP_KEY_HIGH:   win.up_key_high   = val;
            CFG_DOWN_KEY_LOW:  win.down_key_low  = val;
            CFG_DOWN_KEY_HIGH: win.down_key_high = val;
            CFG_SET_KEY_HIGH:  win.set_key_high  = val;
            default: ;
        endcase
    endtask

    task automatic release_cfg();
        cfg_ch.valid <= 1'b0;
        cfg_held = 1'b0;
    endtask

    task automatic write_windows(input key_cfg_t c);
        drain_readouts();
        write_reg(CFG_ALARM_KEY_MAX, c.alarm_key_max);
        write_reg(CFG_UP_KEY_LOW, c.up_key_low);
        write_reg(CFG_UP_KEY_HIGH, c.up_key_high);
        write_reg(CFG_DOWN_KEY_LOW, c.down_key_low);
        write_reg(CFG_DOWN_KEY_HIGH, c.down_key_high);
        write_reg(CFG_SET_KEY_HIGH, c.set_key_high);
        release_cfg();
    endtask

    // ------------------------------------------------------------------
    // Word builders
    // ------------------------------------------------------------------
    function automatic item_t filler_word();
        logic [63:0] fill;
        fill = {$urandom, $urandom};
        return fill[$bits(item_t)-1:0];
    endfunction

    function automatic item_t scan_item(input logic [SAMPLE_W-1:0] s);
        item_t w;
        w = filler_word();
        w.cmd = CMD_SCAN;
        w.key_sample = s;
        return w;
    endfunction

    function automatic item_t rtc_item(input logic [4:0] hh, input logic [5:0] mi,
                                       input logic [5:0] ss, input logic [6:0] yy,
                                       input logic [3:0] mo, input logic [4:0] dd);
        item_t w;
        w = filler_word();
        w.cmd = CMD_RTC;
        w.rtc_hours   = hh;
        w.rtc_minutes = mi;
        w.rtc_seconds = ss;
        w.rtc_year    = yy;
        w.rtc_month   = mo;
        w.rtc_day     = dd;
        return w;
    endfunction

    // Mostly legal clock values, sometimes raw field-width garbage
    function automatic item_t random_rtc_item();
        item_t w;
        w = filler_word();
        w.cmd = CMD_RTC;
        if ($urandom_range(0, 3) != 0)
        begin
            w.rtc_hours   = 5'($urandom_range(0, 23));
            w.rtc_minutes = 6'($urandom_range(0, 59));
            w.rtc_seconds = 6'($urandom_range(0, 59));
            w.rtc_year    = 7'($urandom_range(0, 99));
            w.rtc_month   = 4'($urandom_range(1, 12));
            w.rtc_day     = 5'($urandom_range(1, 31));
        end
        return w;
    endfunction

    // Sample that decodes to the wanted key under the current windows
    function automatic logic [SAMPLE_W-1:0] pick_sample(input key_t k);
        logic [SAMPLE_W-1:0] s;
        int lo;
        int hi;
        lo = 1;
        hi = 0;
        case (k)
            KEY_ALARM:
            begin
                lo = 0;
                hi = win.alarm_key_max;
            end
            KEY_UP:
            begin
                lo = win.up_key_low + 1;
                hi = win.up_key_high - 1;
            end
            KEY_DOWN:
            begin
                lo = win.down_key_low + 1;
                hi = win.down_key_high - 1;
            end
            KEY_SET:
            begin
                lo = win.down_key_high + 1;
                hi = win.set_key_high - 1;
            end
            default: ;
        endcase
        s = 12'($urandom);
        if (lo <= hi)
            s = 12'($urandom_range(hi, lo));
        // fall back to blind tries where a higher window shadows this one
        for (int i = 0; i < 32 && decode_sample(s) != k; i++)
            s = 12'($urandom);
        return s;
    endfunction

    // Any sample, often right on or next to a window bound
    function automatic logic [SAMPLE_W-1:0] noise_sample();
        logic [SAMPLE_W-1:0] bound;
        if ($urandom_range(0, 1) == 0)
            return 12'($urandom);
        bound = win[SAMPLE_W * $urandom_range(0, 5) +: SAMPLE_W];
        return bound + 12'($urandom_range(0, 2)) - 12'd1;
    endfunction

    function automatic key_t pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35) return KEY_ALARM;
        if (roll < 60) return KEY_UP;
        if (roll < 80) return KEY_DOWN;
        return KEY_SET;
    endfunction

    function automatic key_cfg_t ordered_windows();
        key_cfg_t c;
        c.alarm_key_max = 12'($urandom_range(0, 700));
        c.up_key_low    = c.alarm_key_max + 12'($urandom_range(0, 700));
        c.up_key_high   = c.up_key_low + 12'($urandom_range(2, 700));
        c.down_key_low  = c.up_key_high + 12'($urandom_range(0, 400));
        c.down_key_high = c.down_key_low + 12'($urandom_range(2, 700));
        c.set_key_high  = c.down_key_high + 12'($urandom_range(2, 700));
        return c;
    endfunction

    function automatic key_cfg_t default_windows();
        key_cfg_t c;
        c.alarm_key_max = RST_ALARM_KEY_MAX;
        c.up_key_low    = RST_UP_KEY_LOW;
        c.up_key_high   = RST_UP_KEY_HIGH;
        c.down_key_low  = RST_DOWN_KEY_LOW;
        c.down_key_high = RST_DOWN_KEY_HIGH;
        c.set_key_high  = RST_SET_KEY_HIGH;
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Date edit straight after reset: month and day start from zero
    task automatic test_date_edit_from_zero();
        send_word(scan_item(12'd2250));     // no key, reset readout
        send_word(scan_item(12'd2700));     // set: main menu
        send_word(scan_item(12'd1701));     // up: date entry
        send_word(scan_item(12'd0));        // alarm: sub-menu, year
        send_word(scan_item(12'd2600));     // on the down/set bound: no key
        send_word(scan_item(12'd500));      // alarm: month
        send_word(scan_item(12'd2301));     // down: 0 -> 12
        send_word(scan_item(12'd2199));     // up: wraps to 1
        send_word(scan_item(12'd250));      // alarm: day
        send_word(scan_item(12'd2599));     // down: 0 -> 31
        send_word(scan_item(12'd2000));     // up: wraps to 1
    endtask

    // RTC word in the sub-menu is dropped and leaves the held key alone
    task automatic test_rtc_guard_held_key();
        send_word(rtc_item(5'd12, 6'd34, 6'd47, 7'd56, 4'd7, 5'd8));
        send_word(scan_item(12'd2100));     // same up key: no press
        send_word(scan_item(12'd100));      // alarm on last field: commit date
        send_word(scan_item(12'd2601));     // set: back to time
    endtask

    task automatic test_rtc_load_views();
        send_word(rtc_item(5'd31, 6'd63, 6'd63, 7'd127, 4'd15, 5'd31));
        send_word(rtc_item(5'd23, 6'd59, 6'd46, 7'd99, 4'd12, 5'd31));
        send_word(rtc_item(5'd0, 6'd0, 6'd53, 7'd0, 4'd1, 5'd1));
        send_word(rtc_item(5'd9, 6'd15, 6'd54, 7'd20, 4'd2, 5'd29));
        send_word(rtc_item(5'd1, 6'd2, 6'd57, 7'd3, 4'd4, 5'd5));
    endtask

    // Exclusive window bounds decode as no key
    task automatic test_window_bounds();
        send_word(scan_item(12'd1700));
        send_word(scan_item(12'd2200));
        send_word(scan_item(12'd2300));
        send_word(scan_item(12'd2800));
        send_word(scan_item(12'd4095));
    endtask

    task automatic test_spare_cfg_index();
        drain_readouts();
        write_reg(CFG_SPARE_A, 12'($urandom));
        write_reg(CFG_SPARE_B, 12'($urandom));
        release_cfg();
        send_word(scan_item(12'd501));
        send_word(scan_item(12'd500));
    endtask

    task automatic run_random_traffic(input int n_words);
        int   sent;
        int   roll;
        key_t k;
        sent = 0;
        while (sent < n_words)
        begin
            // switch between bursty and steady stretches now and then
            if ($urandom_range(0, 39) == 0)
            begin
                src_quiet  = ($urandom_range(0, 2) == 0);
                sink_quiet = ($urandom_range(0, 2) == 0);
            end
            roll = $urandom_range(0, 99);
            if (roll < 65)
            begin
                k = pick_key();
                send_word(scan_item(pick_sample(k)));
                sent++;
                if ($urandom_range(0, 3) != 0)
                begin
                    send_word(scan_item(pick_sample(KEY_NONE)));
                    sent++;
                end
                else if ($urandom_range(0, 1) == 0)
                begin
                    // button still down on the next scan
                    send_word(scan_item(pick_sample(k)));
                    sent++;
                end
            end
            else if (roll < 80)
            begin
                send_word(random_rtc_item());
                sent++;
            end
            else
            begin
                send_word(scan_item(noise_sample()));
                sent++;
            end
        end
        src_quiet  = 1'b0;
        sink_quiet = 1'b0;
    endtask

    task automatic test_default_windows();
        run_random_traffic(600);
    endtask

    task automatic test_ordered_windows(input int n_words);
        write_windows(ordered_windows());
        run_random_traffic(n_words);
    endtask

    task automatic test_overlapping_windows();
        key_cfg_t c;
        c = 72'({$urandom, $urandom, $urandom});
        write_windows(c);
        run_random_traffic(300);
    endtask

    task automatic test_extreme_windows();
        write_windows('0);
        run_random_traffic(80);
        write_windows('1);
        run_random_traffic(80);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        win          = default_windows();
        m_mode       = MODE_TIME;
        m_entry      = ENTRY_TIME;
        m_field      = FIELD_FIRST;
        m_prev_key   = KEY_NONE;
        m_hours      = '0;
        m_minutes    = '0;
        m_seconds    = '0;
        m_year       = '0;
        m_month      = '0;
        m_day        = '0;
        mismatch_cnt = 0;
        src_quiet    = 1'b0;
        sink_quiet   = 1'b0;
        scan_held    = 1'b0;
        cfg_held     = 1'b0;

        rst_n         <= 1'b0;
        scan_ch.valid <= 1'b0;
        scan_ch.data  <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= CFG_ALARM_KEY_MAX;
        cfg_ch.wdata  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_date_edit_from_zero();
        test_rtc_guard_held_key();
        test_rtc_load_views();
        test_window_bounds();
        test_spare_cfg_index();
        test_default_windows();
        test_ordered_windows(400);
        test_overlapping_windows();
        test_extreme_windows();
        test_ordered_windows(240);

        drain_readouts();
        if (mismatch_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : watchdog
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> files.f
hdl/cbmc_pkg.sv
hdl/cbmc_if.sv
hdl/cbmc_key_dec.sv
hdl/cbmc_menu_core.sv
hdl/clock_button_menu_controller_unit.sv
tb/tb_clock_button_menu_controller_unit.sv
